// ----- design/ssw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssw_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int POS_W       = 31;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 32;
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int CELL_DEPTH  = (MAX_ENTRIES >= 32) ? 32 : 2;
  localparam int CELL_W      = $clog2(CELL_DEPTH);
  localparam int N_CELLS     = (MAX_ENTRIES + CELL_DEPTH - 1) / CELL_DEPTH;
  localparam int CID_W       = COUNT_W - CELL_W;
  localparam int CHAIN_W     = $clog2(N_CELLS + 2);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [BYTE_W-1:0] GAP_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] GAP_UPPER = 8'h4E;
  localparam logic [BYTE_W-1:0] GAP_LOWER = 8'h6E;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [POS_W-1:0]  site_position;
    logic [BYTE_W-1:0] base_byte;
    logic [POS_W-1:0]  window_start;
    logic [POS_W-1:0]  window_end;
  } in_word_t;

  typedef struct packed {
    logic                    accepted;
    logic [COUNT_W-1:0]      sites_in_window;
    logic signed [LEN_W-1:0] ungapped_length;
    logic [POS_W-1:0]        next_start;
    logic [POS_W-1:0]        last_end;
  } out_word_t;

  typedef struct packed {
    logic              en;
    logic [CID_W-1:0]  cell_sel;
    logic [CELL_W-1:0] addr;
    logic [POS_W-1:0]  pos;
    logic              gap;
  } wr_t;

  typedef struct packed {
    logic               clr;
    logic [CELL_W-1:0]  rd_addr;
    logic               proc_vld;
    logic [CELL_W-1:0]  proc_addr;
    logic [POS_W-1:0]   ws;
    logic [POS_W-1:0]   we;
    logic [COUNT_W-1:0] n;
  } scan_t;

  typedef struct packed {
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] gaps;
    logic               next_found;
    logic [POS_W-1:0]   next_pos;
    logic               last_found;
    logic [POS_W-1:0]   last_pos;
  } partial_t;

  function automatic logic is_gap_byte(input logic [BYTE_W-1:0] b);
    return (b == GAP_DASH) || (b == GAP_UPPER) || (b == GAP_LOWER);
  endfunction

endpackage

`default_nettype wire

// ----- design/ssw_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssw_cell (
  input  wire logic                      clk,
  input  wire logic [ssw_pkg::CID_W-1:0] cell_id,
  input  wire ssw_pkg::wr_t              wr,
  input  wire ssw_pkg::scan_t            scan,
  input  wire ssw_pkg::partial_t         chain_in,
  output ssw_pkg::partial_t              chain_out
);

  logic [ssw_pkg::POS_W:0] mem [ssw_pkg::CELL_DEPTH];
  logic [ssw_pkg::POS_W:0] rd_r;

  ssw_pkg::partial_t local_r, local_nxt;
  ssw_pkg::partial_t chain_r, chain_nxt;

  logic [ssw_pkg::COUNT_W-1:0] idx;
  logic [ssw_pkg::POS_W-1:0]   p;
  logic                        g;
  logic                        live;
  logic                        in_win;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.cell_sel == cell_id)) begin
      mem[wr.addr] <= {wr.gap, wr.pos};
    end
    rd_r <= mem[scan.rd_addr];
  end

  always_comb begin
    idx       = {cell_id, scan.proc_addr};
    p         = rd_r[ssw_pkg::POS_W-1:0];
    g         = rd_r[ssw_pkg::POS_W];
    live      = scan.proc_vld && (idx < scan.n);
    in_win    = (p >= scan.ws) && (p < scan.we);
    local_nxt = local_r;
    if (scan.clr) begin
      local_nxt = '0;
    end else if (live) begin
      if (in_win) begin
        if (g) begin
          local_nxt.gaps = local_r.gaps + ssw_pkg::COUNT_W'(1);
        end else begin
          local_nxt.hits = local_r.hits + ssw_pkg::COUNT_W'(1);
        end
      end
      if (!local_r.next_found &&
          (((p >= scan.ws) && !g) ||
           (((idx + ssw_pkg::COUNT_W'(1)) == scan.n) && (p > scan.ws)))) begin
        local_nxt.next_found = 1'b1;
        local_nxt.next_pos   = p;
      end
      if ((p <= scan.we) && !g) begin
        local_nxt.last_found = 1'b1;
        local_nxt.last_pos   = p;
      end
    end
  end

  always_comb begin
    chain_nxt      = chain_in;
    chain_nxt.hits = chain_in.hits + local_r.hits;
    chain_nxt.gaps = chain_in.gaps + local_r.gaps;
    if (!chain_in.next_found) begin
      chain_nxt.next_found = local_r.next_found;
      chain_nxt.next_pos   = local_r.next_pos;
    end
    if (local_r.last_found) begin
      chain_nxt.last_found = 1'b1;
      chain_nxt.last_pos   = local_r.last_pos;
    end
  end

  always_ff @(posedge clk) begin
    local_r <= local_nxt;
    chain_r <= chain_nxt;
  end

  assign chain_out = chain_r;

endmodule

`default_nettype wire

// ----- design/sorted_site_window_query.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Table of variant sites with window queries. A command word on in_data is
// taken at a rising edge where start is high and busy is low. Clear, append
// and the spare opcode answer with one result word on out_data, marked by
// out_valid, in the cycle after acceptance, and busy stays low, so such words
// may follow one another in every cycle. A query raises busy; the table is
// split over a row of cells that each hold 32 entries in a small memory.
// All cells read their entries in parallel, then the partial results ripple
// through the row one cell per cycle. The result word is registered at the
// end of the chain step, and busy falls as it appears, so the next word can
// be taken while the result is shown; no new word is taken before then.
// The result is shown for exactly one cycle and the
// receiver cannot stall it. Reset empties the table and returns the block
// to idle; entry contents are not cleared, since only appended entries are
// ever read.

module sorted_site_window_query (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ssw_pkg::in_word_t in_data,
  output logic                   out_valid,
  output ssw_pkg::out_word_t     out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHAIN
  } state_t;

  state_t                        state_r;
  logic [ssw_pkg::COUNT_W-1:0]   count_r;
  logic [ssw_pkg::POS_W-1:0]     ws_r;
  logic [ssw_pkg::POS_W-1:0]     we_r;
  logic [ssw_pkg::CELL_W-1:0]    scan_cnt_r;
  logic [ssw_pkg::CHAIN_W-1:0]   chain_cnt_r;
  logic                          proc_vld_r;
  logic [ssw_pkg::CELL_W-1:0]    proc_addr_r;
  logic                          out_valid_r;
  ssw_pkg::out_word_t            out_data_r;

  logic                          accept;
  logic                          room;
  ssw_pkg::wr_t                  wr;
  ssw_pkg::scan_t                scan;
  ssw_pkg::partial_t             chain [ssw_pkg::N_CELLS + 1];
  ssw_pkg::partial_t             tail;
  ssw_pkg::out_word_t            result_nxt;
  ssw_pkg::out_word_t            quick_nxt;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign room   = (count_r < ssw_pkg::COUNT_W'(ssw_pkg::MAX_ENTRIES));

  always_comb begin
    wr.en       = accept && (in_data.opcode == ssw_pkg::OP_APPEND) && room;
    wr.cell_sel = count_r[ssw_pkg::COUNT_W-1:ssw_pkg::CELL_W];
    wr.addr     = count_r[ssw_pkg::CELL_W-1:0];
    wr.pos      = in_data.site_position;
    wr.gap      = ssw_pkg::is_gap_byte(in_data.base_byte);
  end

  always_comb begin
    scan.clr       = accept && (in_data.opcode == ssw_pkg::OP_QUERY);
    scan.rd_addr   = scan_cnt_r;
    scan.proc_vld  = proc_vld_r;
    scan.proc_addr = proc_addr_r;
    scan.ws        = ws_r;
    scan.we        = we_r;
    scan.n         = count_r;
  end

  assign chain[0] = '0;

  for (genvar c = 0; c < ssw_pkg::N_CELLS; c++) begin : g_cell
    ssw_cell u_cell (
      .clk       (clk),
      .cell_id   (ssw_pkg::CID_W'(c)),
      .wr        (wr),
      .scan      (scan),
      .chain_in  (chain[c]),
      .chain_out (chain[c+1])
    );
  end

  assign tail = chain[ssw_pkg::N_CELLS];

  always_comb begin
    result_nxt                 = '0;
    result_nxt.accepted        = 1'b1;
    result_nxt.sites_in_window = tail.hits;
    result_nxt.ungapped_length = $signed({1'b0, we_r} - {1'b0, ws_r}
                                         - ssw_pkg::LEN_W'(tail.gaps));
    result_nxt.next_start      = tail.next_found ? tail.next_pos : ws_r;
    if (we_r == '0) begin
      result_nxt.last_end = '0;
    end else begin
      result_nxt.last_end = tail.last_found ? tail.last_pos : we_r;
    end
  end

  always_comb begin
    quick_nxt          = '0;
    quick_nxt.accepted = !((in_data.opcode == ssw_pkg::OP_APPEND) && !room);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      chain_cnt_r <= '0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      proc_vld_r  <= (state_r == S_SCAN);
      proc_addr_r <= scan_cnt_r;
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= start && (in_data.opcode != ssw_pkg::OP_QUERY);
          if (start) begin
            out_data_r <= quick_nxt;
            case (in_data.opcode)
              ssw_pkg::OP_CLEAR: begin
                count_r <= '0;
              end
              ssw_pkg::OP_APPEND: begin
                if (room) begin
                  count_r <= count_r + ssw_pkg::COUNT_W'(1);
                end
              end
              ssw_pkg::OP_QUERY: begin
                ws_r       <= in_data.window_start;
                we_r       <= in_data.window_end;
                scan_cnt_r <= '0;
                state_r    <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          out_valid_r <= 1'b0;
          scan_cnt_r  <= scan_cnt_r + ssw_pkg::CELL_W'(1);
          if (scan_cnt_r == ssw_pkg::CELL_W'(ssw_pkg::CELL_DEPTH - 1)) begin
            chain_cnt_r <= '0;
            state_r     <= S_CHAIN;
          end
        end
        S_CHAIN: begin
          chain_cnt_r <= chain_cnt_r + ssw_pkg::CHAIN_W'(1);
          out_valid_r <= (chain_cnt_r == ssw_pkg::CHAIN_W'(ssw_pkg::N_CELLS + 1));
          if (chain_cnt_r == ssw_pkg::CHAIN_W'(ssw_pkg::N_CELLS + 1)) begin
            out_data_r <= result_nxt;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.opcode == ssw_pkg::OP_QUERY) |=> busy)
    else $error("query word did not raise busy");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.opcode != ssw_pkg::OP_QUERY) |=> out_valid)
    else $error("missing result word after a non-query command");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.opcode == ssw_pkg::OP_APPEND) && !room
    |=> out_valid && !out_data.accepted && $stable(count_r))
    else $error("append to a full table was not rejected");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ssw_pkg::COUNT_W'(ssw_pkg::MAX_ENTRIES))
    else $error("entry count exceeds table size");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while a query is still running");

endmodule

`default_nettype wire
